FILE: hdl/cllm_pkg.sv
// Package for the circular linked list manager.
// Holds the request and response structs, command and status codes and the
// sequencer state type. No dependencies.
package cllm_pkg;

  // Node numbers on the ports are always four bits wide.
  localparam int NODE_W    = 4;
  localparam int NODE_SPAN = 2 ** NODE_W;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_SWAP = 2'd2;

  localparam logic STAT_DONE    = 1'b0;
  localparam logic STAT_REFUSED = 1'b1;

  // Last step of the link rewrite for adjacent and non-adjacent swaps.
  localparam logic [1:0] SW_ADJ_LAST = 2'd2;
  localparam logic [1:0] SW_FAR_LAST = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_req_t;

  typedef struct packed {
    logic              status;
    logic [NODE_W-1:0] head_node;
    logic              list_empty;
    logic [NODE_W-1:0] a_next;
    logic [NODE_W-1:0] a_prev;
  } out_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADD_W1,
    ST_ADD_W2,
    ST_DEL_WR,
    ST_SW_RDY,
    ST_SW_EVAL,
    ST_SW_WR,
    ST_RB_RD,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/cllm_ram.sv
// Generic single-port RAM with registered read data.
// Used for the successor and predecessor link stores. No dependencies.
module cllm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else if (en) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/circular_linked_list_manager.sv
// Circular doubly linked list manager: one command is taken at a time and
// walked through a small sequencer around single-port next and prev link RAMs.
// A command runs check, then any reads and link writes it needs, a read-back of
// node_a's links for add and swap, then done; a new request is taken once the
// response is registered. Each link RAM allows one access per cycle.
// Synchronous active-low reset empties the list; the link RAMs are not cleared.
module circular_linked_list_manager #(
  parameter int NODES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cllm_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cllm_pkg::out_rsp_t out_data
);

  localparam int IDX_W = $clog2(NODES);
  // Only nodes reachable by a four-bit number can ever be members.
  localparam int MEMB  = (NODES < cllm_pkg::NODE_SPAN) ? NODES : cllm_pkg::NODE_SPAN;
  localparam int FW    = $clog2(MEMB);

  typedef logic [cllm_pkg::NODE_W-1:0] node_t;

  cllm_pkg::state_t   state_r, state_nxt;
  cllm_pkg::out_rsp_t out_r;
  logic               out_valid_r;

  logic [1:0]  cmd_r;
  node_t       a_r, b_r, head_r;
  node_t       xp_r, xn_r, yp_r, yn_r;
  logic        present_r;
  logic [MEMB-1:0] flags_r;
  logic        stat_r;
  logic        adj_r;
  logic [1:0]  step_r;

  // Link RAM control.
  logic        n_en, n_we, p_en, p_we;
  node_t       n_addr, n_wd, p_addr, p_wd;
  logic [IDX_W-1:0] n_rdata, p_rdata;
  node_t       n_rd, p_rd;

  function automatic logic is_member(input node_t n, input logic [MEMB-1:0] flags);
    is_member = (32'(n) < MEMB) && flags[n[FW-1:0]];
  endfunction

  // Decode of the latched request.
  logic a_mem, b_mem, add_ok, del_ok, swap_self, swap_ok, refuse;
  logic del_last, eval_adj, eval_two;
  logic xfirst, sw_last;
  node_t first_n, second_n, before_n, after_n;

  assign n_rd = node_t'(n_rdata);
  assign p_rd = node_t'(p_rdata);

  assign a_mem     = is_member(a_r, flags_r);
  assign b_mem     = is_member(b_r, flags_r);
  assign add_ok    = (cmd_r == cllm_pkg::CMD_ADD) && (32'(a_r) < MEMB) && !flags_r[a_r[FW-1:0]];
  assign del_ok    = (cmd_r == cllm_pkg::CMD_DEL) && a_mem;
  assign swap_self = (cmd_r == cllm_pkg::CMD_SWAP) && (a_r == b_r);
  assign swap_ok   = (cmd_r == cllm_pkg::CMD_SWAP) && (a_r != b_r) && a_mem && b_mem;
  assign refuse    = !(add_ok || del_ok || swap_self || swap_ok);

  assign del_last = (head_r == a_r) && (p_rd == a_r);

  // In the evaluate state the links of node_b are still on the RAM outputs.
  assign eval_adj = (xn_r == b_r) || (n_rd == a_r);
  assign eval_two = eval_adj && (xn_r == xp_r);

  assign xfirst   = (xn_r == b_r);
  assign first_n  = xfirst ? a_r  : b_r;
  assign second_n = xfirst ? b_r  : a_r;
  assign before_n = xfirst ? xp_r : yp_r;
  assign after_n  = xfirst ? yn_r : xn_r;
  assign sw_last  = adj_r ? (step_r == cllm_pkg::SW_ADJ_LAST)
                          : (step_r == cllm_pkg::SW_FAR_LAST);

  logic out_free;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == cllm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cllm_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = cllm_pkg::ST_CHECK;
      end
      cllm_pkg::ST_CHECK: begin
        if (add_ok) begin
          state_nxt = present_r ? cllm_pkg::ST_ADD_W1 : cllm_pkg::ST_RB_RD;
        end else if (del_ok) begin
          state_nxt = cllm_pkg::ST_DEL_WR;
        end else if (swap_ok) begin
          state_nxt = cllm_pkg::ST_SW_RDY;
        end else begin
          state_nxt = cllm_pkg::ST_DONE;
        end
      end
      cllm_pkg::ST_ADD_W1:  state_nxt = cllm_pkg::ST_ADD_W2;
      cllm_pkg::ST_ADD_W2:  state_nxt = cllm_pkg::ST_RB_RD;
      cllm_pkg::ST_DEL_WR:  state_nxt = cllm_pkg::ST_DONE;
      cllm_pkg::ST_SW_RDY:  state_nxt = cllm_pkg::ST_SW_EVAL;
      cllm_pkg::ST_SW_EVAL: begin
        state_nxt = eval_two ? cllm_pkg::ST_RB_RD : cllm_pkg::ST_SW_WR;
      end
      cllm_pkg::ST_SW_WR: begin
        if (sw_last) state_nxt = cllm_pkg::ST_RB_RD;
      end
      cllm_pkg::ST_RB_RD:   state_nxt = cllm_pkg::ST_DONE;
      cllm_pkg::ST_DONE: begin
        if (out_free) state_nxt = cllm_pkg::ST_IDLE;
      end
      default: state_nxt = cllm_pkg::ST_IDLE;
    endcase
  end

  // Link RAM accesses for each state.
  always_comb begin
    n_en = 1'b0; n_we = 1'b0; n_addr = a_r; n_wd = a_r;
    p_en = 1'b0; p_we = 1'b0; p_addr = a_r; p_wd = a_r;
    unique case (state_r)
      cllm_pkg::ST_CHECK: begin
        if (add_ok && !present_r) begin
          // First node of an empty list points at itself.
          n_we = 1'b1;
          p_we = 1'b1;
        end else if (add_ok) begin
          p_en   = 1'b1;
          p_addr = head_r;
        end else begin
          n_en = 1'b1;
          p_en = 1'b1;
        end
      end
      cllm_pkg::ST_ADD_W1: begin
        n_we = 1'b1; n_wd = head_r;
        p_we = 1'b1; p_wd = p_rd;
      end
      cllm_pkg::ST_ADD_W2: begin
        n_we = 1'b1; n_addr = xp_r;
        p_we = 1'b1; p_addr = head_r;
      end
      cllm_pkg::ST_DEL_WR: begin
        if (!del_last) begin
          n_we = 1'b1; n_addr = p_rd; n_wd = n_rd;
          p_we = 1'b1; p_addr = n_rd; p_wd = p_rd;
        end
      end
      cllm_pkg::ST_SW_RDY: begin
        n_en = 1'b1; n_addr = b_r;
        p_en = 1'b1; p_addr = b_r;
      end
      cllm_pkg::ST_SW_WR: begin
        n_we = 1'b1;
        p_we = 1'b1;
        if (adj_r) begin
          case (step_r)
            2'd0: begin
              n_addr = before_n; n_wd = second_n;
              p_addr = after_n;  p_wd = first_n;
            end
            2'd1: begin
              n_addr = second_n; n_wd = first_n;
              p_addr = first_n;  p_wd = second_n;
            end
            default: begin
              n_addr = first_n;  n_wd = after_n;
              p_addr = second_n; p_wd = before_n;
            end
          endcase
        end else begin
          case (step_r)
            2'd0: begin
              n_addr = a_r;  n_wd = yn_r;
              p_addr = a_r;  p_wd = yp_r;
            end
            2'd1: begin
              n_addr = b_r;  n_wd = xn_r;
              p_addr = b_r;  p_wd = xp_r;
            end
            2'd2: begin
              n_addr = xp_r; n_wd = b_r;
              p_addr = xn_r; p_wd = b_r;
            end
            default: begin
              n_addr = yp_r; n_wd = a_r;
              p_addr = yn_r; p_wd = a_r;
            end
          endcase
        end
      end
      cllm_pkg::ST_RB_RD: begin
        n_en = 1'b1;
        p_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  cllm_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_next_ram (
    .clk   (clk),
    .en    (n_en),
    .we    (n_we),
    .addr  (IDX_W'(n_addr)),
    .wdata (IDX_W'(n_wd)),
    .rdata (n_rdata)
  );

  cllm_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_prev_ram (
    .clk   (clk),
    .en    (p_en),
    .we    (p_we),
    .addr  (IDX_W'(p_addr)),
    .wdata (IDX_W'(p_wd)),
    .rdata (p_rdata)
  );

  // Control state: sequencer, list head, membership and response valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cllm_pkg::ST_IDLE;
      head_r      <= '0;
      present_r   <= 1'b0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        cllm_pkg::ST_CHECK: begin
          if (add_ok && !present_r) begin
            head_r               <= a_r;
            present_r            <= 1'b1;
            flags_r[a_r[FW-1:0]] <= 1'b1;
          end
        end
        cllm_pkg::ST_ADD_W2: begin
          flags_r[a_r[FW-1:0]] <= 1'b1;
        end
        cllm_pkg::ST_DEL_WR: begin
          flags_r[a_r[FW-1:0]] <= 1'b0;
          if (del_last) begin
            present_r <= 1'b0;
            head_r    <= '0;
          end else if (head_r == a_r) begin
            head_r <= n_rd;
          end
        end
        cllm_pkg::ST_SW_EVAL: begin
          if (head_r == a_r) begin
            head_r <= b_r;
          end else if (head_r == b_r) begin
            head_r <= a_r;
          end
        end
        default: begin
        end
      endcase
      if (state_r == cllm_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      cllm_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_r <= in_data.command;
          a_r   <= in_data.node_a;
          b_r   <= in_data.node_b;
        end
      end
      cllm_pkg::ST_CHECK: begin
        stat_r <= refuse ? cllm_pkg::STAT_REFUSED : cllm_pkg::STAT_DONE;
      end
      cllm_pkg::ST_ADD_W1: begin
        // Old tail, linked to the new node in the next step.
        xp_r <= p_rd;
      end
      cllm_pkg::ST_SW_RDY: begin
        xp_r <= p_rd;
        xn_r <= n_rd;
      end
      cllm_pkg::ST_SW_EVAL: begin
        yp_r   <= p_rd;
        yn_r   <= n_rd;
        adj_r  <= eval_adj;
        step_r <= '0;
      end
      cllm_pkg::ST_SW_WR: begin
        step_r <= step_r + 2'd1;
      end
      cllm_pkg::ST_DONE: begin
        if (out_free) begin
          out_r.status     <= stat_r;
          out_r.head_node  <= present_r ? head_r : '0;
          out_r.list_empty <= !present_r;
          out_r.a_next     <= a_mem ? n_rd : '0;
          out_r.a_prev     <= a_mem ? p_rd : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // The list is present exactly when some node is a member.
  a_present_flags: assert property (@(posedge clk) disable iff (!rst_n)
    present_r == (|flags_r))
    else $error("head present bit disagrees with membership flags");

  // The head is always a member while the list is present.
  a_head_member: assert property (@(posedge clk) disable iff (!rst_n)
    present_r |-> ((32'(head_r) < MEMB) && flags_r[head_r[FW-1:0]]))
    else $error("head node is not a member");

  // An accepted request always starts with the membership check.
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == cllm_pkg::ST_CHECK))
    else $error("accepted request did not enter the check state");

  // Links are never written while the block is waiting for a request.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cllm_pkg::ST_IDLE) |-> (!n_we && !p_we))
    else $error("link RAM written while idle");

  // An empty list is always reported with head zero.
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.list_empty) |-> (out_r.head_node == '0))
    else $error("empty list reported with a nonzero head");

endmodule
